// ===== src/tcgr_pkg.sv =====
// Shared types, constants and helpers of the text console glyph renderer.
// No dependencies; every file but tcgr_ram imports this package.
package tcgr_pkg;

  localparam int FONT_BYTES  = 8192;
  localparam int FONT_AW     = $clog2(FONT_BYTES);
  localparam int GLYPH_WIDTH = 8;
  localparam int LEFT_MARGIN = 8;

  // glyph address: code * height + row, wide enough to compare against the store size
  localparam int GA_W = 15;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  localparam int OQ_DEPTH = 2;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  // input actions
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_RENDER = 2'd1;
  localparam logic [1:0] ACT_CURSOR = 2'd2;

  // special characters
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // result kinds
  localparam logic KIND_ROW    = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  // command kinds in the queue between front and back
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_DRAW  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_GLYPH_HEIGHT  = 2'd2;
  localparam logic [1:0] CFG_BG_COLOR      = 2'd3;

  localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd480;
  localparam logic [5:0]  GLYPH_HEIGHT_RST  = 6'd16;

  typedef struct packed {
    logic [12:0] sw;  // 16..4096
    logic [12:0] sh;  // 1..4096
    logic [5:0]  gh;  // 1..32
  } cfg_t;

  typedef struct packed {
    logic            op;
    logic            scroll;
    logic [GA_W-1:0] addr;
    logic [7:0]      data;
    logic [11:0]     col;
    logic [12:0]     line;
    logic [31:0]     color;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] x_pos;
    logic [12:0] y_pos;
    logic [7:0]  pattern;
    logic [31:0] fg_color;
    logic        last;
  } res_t;

  function automatic logic [12:0] clamp_sw(input logic [12:0] v);
    if (v < 13'd16) return 13'd16;
    if (v > 13'd4096) return 13'd4096;
    return v;
  endfunction

  function automatic logic [12:0] clamp_sh(input logic [12:0] v);
    if (v == 13'd0) return 13'd1;
    if (v > 13'd4096) return 13'd4096;
    return v;
  endfunction

  function automatic logic [5:0] clamp_gh(input logic [5:0] v);
    if (v == 6'd0) return 6'd1;
    if (v > 6'd32) return 6'd32;
    return v;
  endfunction

endpackage

// ===== src/tcgr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module tcgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/tcgr_front.sv =====
// Front end: accepts items, keeps the pixel cursor and turns in-range font loads
// and non-CR renders into font write or glyph draw commands. Depends on tcgr_pkg.
module tcgr_front (
  input  logic            clk,
  input  logic            rst_n,
  input  tcgr_pkg::cfg_t  cfg,
  input  logic            accept,
  input  logic [1:0]      action,
  input  logic [7:0]      char_code,
  input  logic [31:0]     fg_color,
  input  logic [12:0]     font_addr,
  input  logic [7:0]      font_byte,
  input  logic [11:0]     cursor_x,
  input  logic [11:0]     cursor_y,
  output logic            q_push,
  output tcgr_pkg::cmd_t  q_cmd
);
  import tcgr_pkg::*;

  logic [11:0] col_r, col_nxt;
  logic [12:0] line_r, line_nxt;

  logic            is_lf;
  logic [12:0]     nl_line;
  logic [12:0]     d_line_in;
  logic [11:0]     d_col;
  logic [7:0]      d_code;
  logic [31:0]     d_color;
  logic            d_scroll;
  logic [12:0]     d_line;
  logic [GA_W-1:0] d_base;
  logic [12:0]     col_adv;
  logic            wrap;
  logic            load_ok;
  logic            cursor_ok;

  assign is_lf     = (char_code == CH_LF);
  assign nl_line   = line_r + {7'd0, cfg.gh};
  assign d_line_in = is_lf ? nl_line : line_r;
  assign d_col     = is_lf ? 12'(LEFT_MARGIN) : col_r;
  assign d_code    = is_lf ? CH_SPACE : char_code;
  assign d_color   = is_lf ? 32'd0 : fg_color;
  assign d_scroll  = ({1'b0, d_line_in} + {8'd0, cfg.gh}) > {1'b0, cfg.sh};
  // move up one glyph height, saturating at the top line
  assign d_line    = !d_scroll ? d_line_in :
                     (d_line_in >= {7'd0, cfg.gh}) ? d_line_in - {7'd0, cfg.gh} : 13'd0;
  assign d_base    = GA_W'(d_code) * GA_W'(cfg.gh);
  assign col_adv   = {1'b0, col_r} + 13'(GLYPH_WIDTH);
  assign wrap      = ({1'b0, col_adv} + 14'(GLYPH_WIDTH)) > {1'b0, cfg.sw};
  assign load_ok   = GA_W'(font_addr) < GA_W'(FONT_BYTES);
  assign cursor_ok = ({1'b0, cursor_x} <= cfg.sw) && ({1'b0, cursor_y} <= cfg.sh);

  always_comb begin
    col_nxt  = col_r;
    line_nxt = line_r;
    q_push   = 1'b0;
    q_cmd    = '0;
    if (accept) begin
      case (action)
        ACT_LOAD: begin
          if (load_ok) begin
            q_push     = 1'b1;
            q_cmd.op   = CMD_WRITE;
            q_cmd.addr = GA_W'(font_addr);
            q_cmd.data = font_byte;
          end
        end
        ACT_RENDER: begin
          if (char_code == CH_CR) begin
            col_nxt = 12'(LEFT_MARGIN);
          end else begin
            q_push       = 1'b1;
            q_cmd.op     = CMD_DRAW;
            q_cmd.scroll = d_scroll;
            q_cmd.addr   = d_base;
            q_cmd.col    = d_col;
            q_cmd.line   = d_line;
            q_cmd.color  = d_color;
            if (is_lf) begin
              col_nxt  = 12'(LEFT_MARGIN);
              line_nxt = d_line;
            end else if (wrap) begin
              col_nxt  = 12'(LEFT_MARGIN);
              line_nxt = d_line + {7'd0, cfg.gh};
            end else begin
              col_nxt  = col_adv[11:0];
              line_nxt = d_line;
            end
          end
        end
        ACT_CURSOR: begin
          if (cursor_ok) begin
            col_nxt  = cursor_x;
            line_nxt = {1'b0, cursor_y};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      line_r <= '0;
    end else begin
      col_r  <= col_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

// ===== src/tcgr_cmdq.sv =====
// Short command queue between front and back end.
// Depends on tcgr_pkg (cmd_t, queue depth).
module tcgr_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tcgr_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output tcgr_pkg::cmd_t head,
  output logic           empty
);
  import tcgr_pkg::*;

  cmd_t               q_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CMDQ_CW'(push) - CMDQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== src/tcgr_back.sv =====
// Back end (uses tcgr_pkg, tcgr_ram): executes queued commands against the font RAM;
// unless stalled, issues one result per cycle via a read stage into a result queue.
module tcgr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  tcgr_pkg::cfg_t cfg,
  input  tcgr_pkg::cmd_t q_head,
  input  logic           q_empty,
  output logic           q_pop,
  output tcgr_pkg::res_t out_res,
  output logic           out_empty,
  input  logic           out_pop
);
  import tcgr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_ROWS = 1'b1;
  localparam int   OCC_W   = OQ_CW + 1;

  logic            state_r, state_nxt;
  logic [5:0]      row_r, row_nxt;
  logic            scroll_pend_r, scroll_pend_nxt;
  logic [GA_W-1:0] base_r, base_nxt;
  logic [11:0]     col_r, col_nxt;
  logic [12:0]     line_r, line_nxt;
  logic [31:0]     color_r, color_nxt;

  logic            stg_vld_r, stg_vld_nxt;
  res_t            stg_res_r, stg_res_nxt;
  logic            stg_ram_r, stg_ram_nxt;

  res_t            oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wr_r, oq_rd_r;
  logic [OQ_CW-1:0] oq_cnt_r;
  logic            pop_ok;
  logic            issue_ok;

  logic            ram_we;
  logic            ram_re;
  logic [GA_W-1:0] row_addr;
  logic            row_inb;
  logic            row_last;
  logic [7:0]      ram_rdata;
  res_t            stg_out;

  tcgr_ram #(
    .WIDTH (8),
    .DEPTH (FONT_BYTES)
  ) u_font (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_head.addr[FONT_AW-1:0]),
    .wdata (q_head.data),
    .re    (ram_re),
    .raddr (row_addr[FONT_AW-1:0]),
    .rdata (ram_rdata)
  );

  assign pop_ok    = out_pop && !out_empty;
  assign out_empty = (oq_cnt_r == '0);
  assign out_res   = oq_r[oq_rd_r];
  // issue only when the staged result and this one both find room
  assign issue_ok  = (OCC_W'(oq_cnt_r) + OCC_W'(stg_vld_r)) <
                     (OCC_W'(OQ_DEPTH) + OCC_W'(pop_ok));
  assign row_addr  = base_r + GA_W'(row_r);
  assign row_inb   = row_addr < GA_W'(FONT_BYTES);
  assign row_last  = (row_r == cfg.gh - 6'd1);

  always_comb begin
    state_nxt       = state_r;
    row_nxt         = row_r;
    scroll_pend_nxt = scroll_pend_r;
    base_nxt        = base_r;
    col_nxt         = col_r;
    line_nxt        = line_r;
    color_nxt       = color_r;
    stg_vld_nxt     = 1'b0;
    stg_res_nxt     = stg_res_r;
    stg_ram_nxt     = 1'b0;
    q_pop           = 1'b0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.op == CMD_WRITE) begin
            ram_we = 1'b1;
          end else begin
            state_nxt       = ST_ROWS;
            row_nxt         = '0;
            scroll_pend_nxt = q_head.scroll;
            base_nxt        = q_head.addr;
            col_nxt         = q_head.col;
            line_nxt        = q_head.line;
            color_nxt       = q_head.color;
          end
        end
      end
      ST_ROWS: begin
        if (issue_ok) begin
          stg_vld_nxt = 1'b1;
          if (scroll_pend_r) begin
            scroll_pend_nxt = 1'b0;
            stg_res_nxt     = '0;
            stg_res_nxt.kind = KIND_SCROLL;
          end else begin
            ram_re               = row_inb;
            stg_ram_nxt          = row_inb;
            stg_res_nxt.kind     = KIND_ROW;
            stg_res_nxt.x_pos    = col_r;
            stg_res_nxt.y_pos    = line_r + {7'd0, row_r};
            stg_res_nxt.pattern  = 8'd0;
            stg_res_nxt.fg_color = color_r;
            stg_res_nxt.last     = row_last;
            row_nxt              = row_r + 6'd1;
            if (row_last) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // merge the font byte arriving from the RAM into the staged result
  always_comb begin
    stg_out         = stg_res_r;
    stg_out.pattern = stg_ram_r ? ram_rdata : 8'd0;
  end

  always_ff @(posedge clk) begin
    base_r    <= base_nxt;
    col_r     <= col_nxt;
    line_r    <= line_nxt;
    color_r   <= color_nxt;
    stg_res_r <= stg_res_nxt;
    stg_ram_r <= stg_ram_nxt;
    if (stg_vld_r) begin
      oq_r[oq_wr_r] <= stg_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      row_r         <= '0;
      scroll_pend_r <= 1'b0;
      stg_vld_r     <= 1'b0;
      oq_wr_r       <= '0;
      oq_rd_r       <= '0;
      oq_cnt_r      <= '0;
    end else begin
      state_r       <= state_nxt;
      row_r         <= row_nxt;
      scroll_pend_r <= scroll_pend_nxt;
      stg_vld_r     <= stg_vld_nxt;
      if (stg_vld_r) begin
        oq_wr_r <= (oq_wr_r == OQ_AW'(OQ_DEPTH - 1)) ? '0 : oq_wr_r + 1'b1;
      end
      if (pop_ok) begin
        oq_rd_r <= (oq_rd_r == OQ_AW'(OQ_DEPTH - 1)) ? '0 : oq_rd_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_r + OQ_CW'(stg_vld_r) - OQ_CW'(pop_ok);
    end
  end

`ifndef ASSERT_OFF
  a_stage_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_r |-> (oq_cnt_r != OQ_CW'(OQ_DEPTH)) || pop_ok)
    else $error("staged result found the result queue full");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROWS |-> row_r < cfg.gh)
    else $error("row counter beyond glyph height");

  a_scroll_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_r && stg_res_r.kind == KIND_SCROLL |-> !stg_res_r.last)
    else $error("scroll command flagged as last result");

  a_last_ends_draw: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_r && stg_res_r.kind == KIND_ROW && stg_res_r.last |-> state_r == ST_IDLE)
    else $error("last glyph row issued while the sequencer stays busy");
`endif

endmodule

// ===== src/text_console_glyph_renderer.sv =====
// Text console glyph renderer. Items enter through a push/full port and results
// leave through an empty/pop port. Set-cursor and carriage-return items are taken
// by the front end and give no result. Font loads and character renders pass
// through a two-entry command queue to the back end. There a load writes the font
// RAM as it leaves the queue. A render leaves the queue, then gives a scroll
// result first if it scrolls and one row result per glyph row; the back end takes
// no new command until the last row is issued. Its sequencer issues one font RAM
// read and one row result per cycle while the result queue has room. The font
// store is a single-port-read RAM with no reset, so load font entries before use.
// Configuration writes take effect at once. Make them only while the block is
// idle. Background colour writes are accepted but not stored; the consumer does
// the fill. Depends on tcgr_pkg, tcgr_front, tcgr_cmdq, tcgr_back.
module text_console_glyph_renderer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_char_code,
  input  logic [31:0] in_fg_color_in,
  input  logic [12:0] in_font_addr,
  input  logic [7:0]  in_font_byte,
  input  logic [11:0] in_cursor_x_in,
  input  logic [11:0] in_cursor_y_in,
  output logic        empty,
  input  logic        pop,
  output logic        out_kind,
  output logic [11:0] out_x_pos,
  output logic [12:0] out_y_pos,
  output logic [7:0]  out_pattern,
  output logic [31:0] out_fg_color_out,
  output logic        out_last
);
  import tcgr_pkg::*;

  logic [12:0] sw_r, sw_nxt;
  logic [12:0] sh_r, sh_nxt;
  logic [5:0]  gh_r, gh_nxt;
  cfg_t        cfg;

  logic accept;
  logic q_push;
  cmd_t q_cmd;
  logic q_full;
  logic q_pop;
  cmd_t q_head;
  logic q_empty;
  res_t res;

  always_comb begin
    sw_nxt = sw_r;
    sh_nxt = sh_r;
    gh_nxt = gh_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_SCREEN_WIDTH:  sw_nxt = cfg_wdata[12:0];
        CFG_SCREEN_HEIGHT: sh_nxt = cfg_wdata[12:0];
        CFG_GLYPH_HEIGHT:  gh_nxt = cfg_wdata[5:0];
        CFG_BG_COLOR: begin
          // fill colour is applied downstream; nothing to hold here
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= SCREEN_WIDTH_RST;
      sh_r <= SCREEN_HEIGHT_RST;
      gh_r <= GLYPH_HEIGHT_RST;
    end else begin
      sw_r <= sw_nxt;
      sh_r <= sh_nxt;
      gh_r <= gh_nxt;
    end
  end

  assign cfg.sw = clamp_sw(sw_r);
  assign cfg.sh = clamp_sh(sh_r);
  assign cfg.gh = clamp_gh(gh_r);

  assign full   = q_full;
  assign accept = push && !q_full;

  tcgr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .accept    (accept),
    .action    (in_action),
    .char_code (in_char_code),
    .fg_color  (in_fg_color_in),
    .font_addr (in_font_addr),
    .font_byte (in_font_byte),
    .cursor_x  (in_cursor_x_in),
    .cursor_y  (in_cursor_y_in),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  tcgr_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  tcgr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_res   (res),
    .out_empty (empty),
    .out_pop   (pop)
  );

  assign out_kind         = res.kind;
  assign out_x_pos        = res.x_pos;
  assign out_y_pos        = res.y_pos;
  assign out_pattern      = res.pattern;
  assign out_fg_color_out = res.fg_color;
  assign out_last         = res.last;

endmodule
